### src/pe_pkg.sv
// ----------------------------------------------------------------------------
// pe_pkg
// Shared types and constants for the polynomial evaluator.
// ----------------------------------------------------------------------------
package pe_pkg;

    localparam int MAX_TERMS_DEFAULT = 16;
    localparam int COEF_W            = 32;
    localparam int ACC_W             = 64;
    localparam int DEG_W             = 4;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic        [ACC_W-1:0]  acc_t;

endpackage

### src/pe_mac_unit.sv
// ----------------------------------------------------------------------------
// pe_mac_unit
// One Horner step acc * x + c, modulo 2^64, on a shared 32x32 multiplier.
// First phase forms the low partial product, second phase the high one.
// ----------------------------------------------------------------------------
module pe_mac_unit
    import pe_pkg::*;
(
    input  logic  clk,
    input  logic  lo_phase,
    input  acc_t  acc,
    input  coef_t x,
    input  coef_t coef,
    output acc_t  acc_next
);

    logic [COEF_W-1:0]   mul_a;
    logic [2*COEF_W-1:0] prod;
    logic [2*COEF_W-1:0] lo_prod_reg;
    logic [COEF_W-1:0]   hi_part;
    logic [COEF_W-1:0]   corr;

    assign mul_a = lo_phase ? acc[COEF_W-1:0] : acc[ACC_W-1:COEF_W];
    assign prod  = {{COEF_W{1'b0}}, mul_a} * {{COEF_W{1'b0}}, x[COEF_W-1:0]};

    always_ff @(posedge clk)
    begin
        if (lo_phase)
        begin
            lo_prod_reg <= prod;
        end
    end

    // negative x: subtract acc_lo from the upper half
    assign corr     = x[COEF_W-1] ? acc[COEF_W-1:0] : '0;
    assign hi_part  = prod[COEF_W-1:0] - corr;
    assign acc_next = lo_prod_reg + {hi_part, {COEF_W{1'b0}}}
                    + {{(ACC_W-COEF_W){coef[COEF_W-1]}}, coef};

endmodule

### src/polynomial_evaluator.sv
// ----------------------------------------------------------------------------
// polynomial_evaluator
// Coefficient table with Horner-rule evaluation, 64-bit wrapping result.
// ----------------------------------------------------------------------------
// A load transaction (opcode 0) writes one coefficient and gives no result.
// An evaluate transaction (opcode 1) clamps the degree to MAX_TERMS - 1; each
// Horner step passes twice through the single shared 32x32 multiplier, low
// partial product then high partial product with the add. in_ready is low
// while an evaluation runs. The result sits in an output register, so the
// next transaction is taken while it waits; a finishing evaluation holds only
// if the previous result has not been taken. Coefficients never loaded read
// as undefined.
// ----------------------------------------------------------------------------
module polynomial_evaluator
    import pe_pkg::*;
#(
    parameter int MAX_TERMS = MAX_TERMS_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [DEG_W-1:0]   cfg_wr_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               opcode,
    input  logic [DEG_W-1:0]   coef_index,
    input  coef_t              coef_value,
    input  coef_t              eval_point,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [ACC_W-1:0] poly_value
);

    localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LO   = 2'd1;
    localparam logic [1:0] S_HI   = 2'd2;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic [DEG_W-1:0] degree_reg;
    logic [IDX_W-1:0] k_reg;
    logic [IDX_W-1:0] k_next;
    logic [IDX_W-1:0] top;
    logic [IDX_W-1:0] wr_addr;
    acc_t             acc_reg;
    acc_t             acc_next;
    coef_t            x_reg;
    coef_t            coef_reg;
    logic             out_valid_reg;
    acc_t             poly_value_reg;
    logic             in_fire;
    logic             out_load;
    logic             load_ok;

    coef_t coef_mem [MAX_TERMS];

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign poly_value = poly_value_reg;

    assign top     = (int'(degree_reg) > MAX_TERMS - 1) ? IDX_W'(MAX_TERMS - 1)
                                                       : IDX_W'(degree_reg);
    assign wr_addr = IDX_W'(coef_index);
    assign load_ok = int'(coef_index) < MAX_TERMS;
    assign out_load = (state_reg == S_HI) && (k_reg == '0)
                   && (!out_valid_reg || out_ready);

    pe_mac_unit u_mac (
        .clk      (clk),
        .lo_phase (state_reg == S_LO),
        .acc      (acc_reg),
        .x        (x_reg),
        .coef     (coef_reg),
        .acc_next (acc_next)
    );

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire && opcode == OP_EVAL)
                begin
                    state_next = S_LO;
                    k_next     = top;
                end
            end
            S_LO:
            begin
                state_next = S_HI;
            end
            S_HI:
            begin
                if (k_reg != '0)
                begin
                    state_next = S_LO;
                    k_next     = k_reg - 1'b1;
                end
                else if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            degree_reg    <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            if (cfg_wr_en)
            begin
                degree_reg <= cfg_wr_data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && opcode == OP_LOAD && load_ok)
        begin
            coef_mem[wr_addr] <= coef_value;
        end
        if (state_reg == S_LO)
        begin
            coef_reg <= coef_mem[k_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            x_reg   <= eval_point;
            acc_reg <= '0;
        end
        else if (state_reg == S_HI && k_reg != '0)
        begin
            acc_reg <= acc_next;
        end
        if (out_load)
        begin
            poly_value_reg <= acc_next;
        end
    end

    a_eval_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && opcode == OP_EVAL) |=> (state_reg == S_LO))
        else $error("evaluate transaction did not start the sequencer");

    a_lo_then_hi: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LO) |=> (state_reg == S_HI))
        else $error("low product phase not followed by high phase");

    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ready)
        else $error("ready raised during evaluation");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(poly_value)))
        else $error("pending result lost or changed");

endmodule
